>>> rtl/core/mfpf_pkg.sv
// mfpf_pkg: shared widths, constants and types of the matched filter peak finder
`timescale 1ns / 1ps

package mfpf_pkg;

    // default parameter values
    localparam int DEF_TAPS          = 5;
    localparam int DEF_MAX_PULSE_LEN = 32;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int VALUE_W   = 24;
    localparam int INDEX_W   = 5;
    localparam int CELL_W    = 64;
    localparam int FRAC_BITS = 16;

    // configuration port
    localparam int CFG_IW    = 3;
    localparam int REG_COUNT = 5;
    localparam logic [CFG_IW-1:0] REG_COEF_0 = 3'd0;

    // saturation bounds of the filter output
    localparam logic signed [VALUE_W-1:0] SAT_HI = 24'sh7FFFFF;
    localparam logic signed [VALUE_W-1:0] SAT_LO = 24'sh800000;

    // side data that follows one result through the filter pipeline
    typedef struct packed {
        logic [INDEX_W-1:0] idx;
        logic               fin;
        logic               overlong;
        logic [CELL_W-1:0]  tag;
    } t_meta;

endpackage

>>> rtl/core/mfpf_if.sv
// mfpf_if: channel interfaces for samples, results and configuration writes
`timescale 1ns / 1ps

interface mfpf_in_if
    import mfpf_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CELL_W-1:0]          cell_id;
    logic                       pulse_last;

    modport source (output valid, sample, cell_id, pulse_last, input ready);
    modport sink (input valid, sample, cell_id, pulse_last, output ready);
endinterface

interface mfpf_out_if
    import mfpf_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] filtered_value;
    logic [INDEX_W-1:0]        output_index;
    logic [CELL_W-1:0]         cell_tag;
    logic                      final_output;
    logic signed [VALUE_W-1:0] peak_value;
    logic [INDEX_W-1:0]        peak_index;
    logic                      length_error;

    modport source (output valid, filtered_value, output_index, cell_tag, final_output,
                    peak_value, peak_index, length_error, input ready);
    modport sink (input valid, filtered_value, output_index, cell_tag, final_output,
                  peak_value, peak_index, length_error, output ready);
endinterface

interface mfpf_cfg_if
    import mfpf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [COEF_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/mfpf_mac.sv
// mfpf_mac: two-stage multiply and sum with floor shift and saturation
`timescale 1ns / 1ps

module mfpf_mac
    import mfpf_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [COEF_W-1:0]   i_coef [TAPS],
    input  logic signed [SAMPLE_W-1:0] i_win [TAPS],
    input  t_meta                      i_meta,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [VALUE_W-1:0]  o_value,
    output t_meta                      o_meta
);

    localparam int PW = COEF_W + SAMPLE_W;
    localparam int SW = PW + $clog2(TAPS) + 1;

    logic                 r_p_valid;
    logic signed [PW-1:0] r_prod [TAPS];
    t_meta                r_p_meta;
    logic                 r_s_valid;
    logic signed [VALUE_W-1:0] r_s_value;
    t_meta                r_s_meta;

    logic                 adv_s;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;
    logic signed [VALUE_W-1:0] n_value;

    // stall chain
    assign adv_s   = !r_s_valid || i_ready;
    assign o_ready = !r_p_valid || adv_s;

    // product stage: one multiplier per tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (o_ready) begin
            r_p_valid <= i_valid;
        end
        if (o_ready) begin
            for (int t = 0; t < TAPS; t++) begin
                r_prod[t] <= PW'(i_coef[t]) * PW'(i_win[t]);
            end
            r_p_meta <= i_meta;
        end
    end

    // sum, floor shift and saturate
    always_comb begin
        sum = '0;
        for (int t = 0; t < TAPS; t++) begin
            sum = sum + SW'(r_prod[t]);
        end
        shifted = sum >>> FRAC_BITS;
        if (shifted > SW'(SAT_HI)) begin
            n_value = SAT_HI;
        end else if (shifted < SW'(SAT_LO)) begin
            n_value = SAT_LO;
        end else begin
            n_value = VALUE_W'(shifted);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (adv_s) begin
            r_s_valid <= r_p_valid;
        end
        if (adv_s) begin
            r_s_value <= n_value;
            r_s_meta  <= r_p_meta;
        end
    end

    assign o_valid = r_s_valid;
    assign o_value = r_s_value;
    assign o_meta  = r_s_meta;

endmodule

>>> rtl/core/matched_filter_peak_finder_top.sv
// matched_filter_peak_finder_top: sample window, flush sequencer, filter and peak tracking
`timescale 1ns / 1ps

// channel   modport  beat
// i_in      sink     one pulse sample with cell id and last-of-pulse mark
// o_out     source   one filter output, with peak and error on the pulse's last output
// i_cfg     sink     one coefficient write, register index and data
//
// A sample is taken every cycle unless a flush or an o_out stall holds i_in.ready low;
// a non-last sample yields at most one output, the last one of a pulse a flush of
// min(n, (TAPS-1)/2) + 1 outputs, one per cycle unless stalled, n being its position in
// the pulse. A beat passes the job, mac product, mac sum and output registers in order.
// Reset is synchronous and clears window, counters, peak and all valid bits.
// A stall on o_out holds the pipeline; bubbles in it are still filled.

module matched_filter_peak_finder_top
    import mfpf_pkg::*;
#(
    parameter int TAPS          = DEF_TAPS,
    parameter int MAX_PULSE_LEN = DEF_MAX_PULSE_LEN
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mfpf_in_if.sink    i_in,
    mfpf_out_if.source o_out,
    mfpf_cfg_if.sink   i_cfg
);

    localparam int AHEAD   = (TAPS - 1) / 2;
    localparam int CW      = $clog2(MAX_PULSE_LEN + TAPS);
    localparam int CNT_MAX = MAX_PULSE_LEN + TAPS - 1;
    localparam int JW      = $clog2(AHEAD + 2);
    localparam int IDX_CAP = (MAX_PULSE_LEN - 1 > 31) ? 31 : MAX_PULSE_LEN - 1;
    localparam int XW      = (CW > INDEX_W) ? CW : INDEX_W;

    // coefficients
    logic signed [COEF_W-1:0] r_coef [TAPS];

    // pulse state
    logic signed [SAMPLE_W-1:0] r_win [TAPS];
    logic [CW-1:0]              r_cnt;
    logic                       r_overlong;
    logic [CELL_W-1:0]          r_cell;

    // flush sequencer
    logic                       r_job_valid;
    logic signed [SAMPLE_W-1:0] r_job_win [TAPS];
    logic [CW-1:0]              r_job_idx;
    logic [JW-1:0]              r_job_rem;
    logic                       r_job_last;
    logic                       r_job_overlong;
    logic [CELL_W-1:0]          r_job_cell;

    // output stage
    logic                      r_o_valid;
    logic signed [VALUE_W-1:0] r_o_value;
    logic [INDEX_W-1:0]        r_o_idx;
    logic [CELL_W-1:0]         r_o_cell;
    logic                      r_o_fin;
    logic signed [VALUE_W-1:0] r_o_peak;
    logic [INDEX_W-1:0]        r_o_peak_idx;
    logic                      r_o_err;
    logic signed [VALUE_W-1:0] r_best;
    logic [INDEX_W-1:0]        r_best_idx;

    logic                       in_acc;
    logic                       job_done;
    logic                       mac_ready;
    logic                       mac_valid;
    logic signed [VALUE_W-1:0]  mac_value;
    t_meta                      mac_meta;
    t_meta                      job_meta;
    logic                       adv_o;
    logic signed [SAMPLE_W-1:0] s_win [TAPS];
    logic signed [SAMPLE_W-1:0] n_job_win [TAPS];
    logic [CELL_W-1:0]          n_cell;
    logic                       n_overlong;
    logic                       n_job_load;
    logic [JW-1:0]              n_j0;
    logic [JW-1:0]              n_shift;
    logic [XW-1:0]              idx_ext;
    logic                       better;
    logic signed [VALUE_W-1:0]  n_best;
    logic [INDEX_W-1:0]         n_best_idx;

    // coefficient writes, indexes past the used taps are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                r_coef[t] <= '0;
            end
        end else if (i_cfg.valid) begin
            for (int t = 0; t < TAPS; t++) begin
                if (i_cfg.index == REG_COEF_0 + CFG_IW'(t)) begin
                    r_coef[t] <= i_cfg.data;
                end
            end
        end
    end

    // handshake on the sample side
    assign job_done = r_job_valid && (r_job_rem == '0) && mac_ready;
    assign i_in.ready = !r_job_valid || job_done;
    assign in_acc = i_in.valid && i_in.ready;

    // window after taking the new sample, and the flush job it starts
    always_comb begin
        for (int i = 0; i + 1 < TAPS; i++) begin
            s_win[i] = r_win[i + 1];
        end
        s_win[TAPS-1] = i_in.sample;
        n_cell     = (r_cnt == '0) ? i_in.cell_id : r_cell;
        n_overlong = r_overlong || (r_cnt >= CW'(MAX_PULSE_LEN));
        n_job_load = i_in.pulse_last || (r_cnt >= CW'(AHEAD));
        if (!i_in.pulse_last || (r_cnt >= CW'(AHEAD))) begin
            n_j0 = JW'(AHEAD);
        end else begin
            n_j0 = JW'(r_cnt);
        end
        n_shift = JW'(AHEAD) - n_j0;
        // pre-shift so the taps always line up with the window slots
        for (int i = 0; i < TAPS; i++) begin
            n_job_win[i] = '0;
        end
        for (int k = 0; k <= AHEAD; k++) begin
            if (n_shift == JW'(k)) begin
                for (int i = 0; i + k < TAPS; i++) begin
                    n_job_win[i] = s_win[i + k];
                end
            end
        end
    end

    // pulse state, cleared after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_win[i] <= '0;
            end
            r_cnt      <= '0;
            r_overlong <= 1'b0;
            r_cell     <= '0;
        end else if (in_acc) begin
            if (i_in.pulse_last) begin
                for (int i = 0; i < TAPS; i++) begin
                    r_win[i] <= '0;
                end
                r_cnt      <= '0;
                r_overlong <= 1'b0;
                r_cell     <= '0;
            end else begin
                r_win      <= s_win;
                r_cnt      <= (r_cnt == CW'(CNT_MAX)) ? r_cnt : r_cnt + 1'b1;
                r_overlong <= n_overlong;
                r_cell     <= n_cell;
            end
        end
    end

    // flush sequencer: one output per cycle unless u_mac stalls, window slides to zero fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (in_acc) begin
            r_job_valid <= n_job_load;
        end else if (job_done) begin
            r_job_valid <= 1'b0;
        end
        if (in_acc) begin
            r_job_win      <= n_job_win;
            r_job_idx      <= r_cnt - CW'(n_j0);
            r_job_rem      <= i_in.pulse_last ? n_j0 : '0;
            r_job_last     <= i_in.pulse_last;
            r_job_overlong <= n_overlong;
            r_job_cell     <= n_cell;
        end else if (r_job_valid && mac_ready && (r_job_rem != '0)) begin
            for (int i = 0; i + 1 < TAPS; i++) begin
                r_job_win[i] <= r_job_win[i + 1];
            end
            r_job_win[TAPS-1] <= '0;
            r_job_idx <= r_job_idx + 1'b1;
            r_job_rem <= r_job_rem - 1'b1;
        end
    end

    // index saturation and side data for the filter
    always_comb begin
        idx_ext = XW'(r_job_idx);
        job_meta.idx = (idx_ext > XW'(IDX_CAP)) ? INDEX_W'(IDX_CAP) : INDEX_W'(idx_ext);
        job_meta.fin      = r_job_last && (r_job_rem == '0);
        job_meta.overlong = r_job_overlong;
        job_meta.tag      = r_job_cell;
    end

    mfpf_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_job_valid),
        .o_ready (mac_ready),
        .i_coef  (r_coef),
        .i_win   (r_job_win),
        .i_meta  (job_meta),
        .o_valid (mac_valid),
        .i_ready (adv_o),
        .o_value (mac_value),
        .o_meta  (mac_meta)
    );

    // peak tracking, first maximum wins
    assign adv_o = !r_o_valid || o_out.ready;

    always_comb begin
        better     = mac_value > r_best;
        n_best     = better ? mac_value : r_best;
        n_best_idx = better ? mac_meta.idx : r_best_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_best     <= SAT_LO;
            r_best_idx <= '0;
        end else if (adv_o) begin
            r_o_valid <= mac_valid;
            if (mac_valid) begin
                r_best     <= mac_meta.fin ? SAT_LO : n_best;
                r_best_idx <= mac_meta.fin ? '0 : n_best_idx;
            end
        end
        if (adv_o) begin
            r_o_value    <= mac_value;
            r_o_idx      <= mac_meta.idx;
            r_o_cell     <= mac_meta.tag;
            r_o_fin      <= mac_meta.fin;
            r_o_peak     <= mac_meta.fin ? n_best : '0;
            r_o_peak_idx <= mac_meta.fin ? n_best_idx : '0;
            r_o_err      <= mac_meta.fin && mac_meta.overlong;
        end
    end

    // result beat
    assign o_out.valid          = r_o_valid;
    assign o_out.filtered_value = r_o_value;
    assign o_out.output_index   = r_o_idx;
    assign o_out.cell_tag       = r_o_cell;
    assign o_out.final_output   = r_o_fin;
    assign o_out.peak_value     = r_o_peak;
    assign o_out.peak_index     = r_o_peak_idx;
    assign o_out.length_error   = r_o_err;

endmodule

>>> dv/mfpf_output_checker.sv
// mfpf_output_checker: predicts filter outputs and pulse peaks from observed beats and compares them
`timescale 1ns / 1ps

module mfpf_output_checker
    import mfpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mfpf_in_if   i_in,
    mfpf_out_if  i_out,
    mfpf_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int TAPS       = DEF_TAPS;
    localparam int LOOKAHEAD  = (TAPS - 1) / 2;
    localparam int INDEX_TOP  = (1 << INDEX_W) - 1;
    localparam int INDEX_CAP  = (DEF_MAX_PULSE_LEN - 1 < INDEX_TOP) ?
                                DEF_MAX_PULSE_LEN - 1 : INDEX_TOP;
    localparam int COUNT_CAP  = 65535;
    localparam int REPORT_MAX = 10;

    // one filter output as it should appear on the result channel
    typedef struct packed {
        logic signed [VALUE_W-1:0] filtered;
        logic [INDEX_W-1:0]        index;
        logic [CELL_W-1:0]         tag;
        logic                      last;
        logic signed [VALUE_W-1:0] peak;
        logic [INDEX_W-1:0]        peak_idx;
        logic                      len_err;
    } mf_output_t;

    logic signed [COEF_W-1:0]   coef_q   [REG_COUNT];
    logic signed [SAMPLE_W-1:0] window_q [TAPS];
    int                         seen_count;
    logic signed [VALUE_W-1:0]  best_value;
    logic [INDEX_W-1:0]         best_index;
    logic [CELL_W-1:0]          held_cell;
    logic                       overlong;
    mf_output_t                 expected_outputs [$];
    int                         mismatches = 0;
    int                         compared = 0;

    // pulse state back to its idle value
    function automatic void clear_pulse();
        for (int i = 0; i < TAPS; i++) window_q[i] = '0;
        seen_count = 0;
        best_value = SAT_LO;
        best_index = '0;
        held_cell  = '0;
        overlong   = 1'b0;
    endfunction

    // centered correlation for the output lag samples behind the newest one
    function automatic logic signed [VALUE_W-1:0] filter_at(int lag);
        longint acc;
        int     pos;
        acc = 0;
        for (int t = 0; t < TAPS; t++) begin
            pos = TAPS - 1 - lag - TAPS / 2 + t;
            if (pos >= 0 && pos < TAPS) begin
                acc += longint'(coef_q[t]) * longint'(window_q[pos]);
            end
        end
        acc = acc >>> FRAC_BITS;
        if (acc > longint'(SAT_HI)) acc = longint'(SAT_HI);
        if (acc < longint'(SAT_LO)) acc = longint'(SAT_LO);
        return VALUE_W'(acc);
    endfunction

    // track the first maximum and queue the output
    function automatic void push_output(logic signed [VALUE_W-1:0] value, int pos, logic fin);
        mf_output_t         r;
        logic [INDEX_W-1:0] idx;
        idx = (pos > INDEX_CAP) ? INDEX_W'(INDEX_CAP) : INDEX_W'(pos);
        if (value > best_value) begin
            best_value = value;
            best_index = idx;
        end
        r.filtered = value;
        r.index    = idx;
        r.tag      = held_cell;
        r.last     = fin;
        r.peak     = fin ? best_value : '0;
        r.peak_idx = fin ? best_index : '0;
        r.len_err  = fin && overlong;
        expected_outputs = {expected_outputs, r};
    endfunction

    // one accepted sample: shift it in, emit what is complete, flush on the last
    function automatic void filter_sample(logic signed [SAMPLE_W-1:0] sample,
                                          logic [CELL_W-1:0] cell_in, logic last);
        int n;
        int lag;
        n = seen_count;
        if (n == 0) held_cell = cell_in;
        for (int i = 0; i < TAPS - 1; i++) window_q[i] = window_q[i + 1];
        window_q[TAPS - 1] = sample;
        if (seen_count < COUNT_CAP) seen_count++;
        if (n >= DEF_MAX_PULSE_LEN) overlong = 1'b1;
        if (!last) begin
            if (n >= LOOKAHEAD) push_output(filter_at(LOOKAHEAD), n - LOOKAHEAD, 1'b0);
        end else begin
            lag = (n < LOOKAHEAD) ? n : LOOKAHEAD;
            while (lag >= 0) begin
                push_output(filter_at(lag), n - lag, lag == 0);
                lag--;
            end
            clear_pulse();
        end
    endfunction

    function automatic void compare_field(string field, logic [CELL_W-1:0] want,
                                          logic [CELL_W-1:0] got);
        if (want !== got) begin
            if (mismatches < REPORT_MAX) begin
                $display("%t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            end
            mismatches++;
        end
    endfunction

    // one result beat against the oldest expectation
    function automatic void check_result();
        mf_output_t want;
        if (expected_outputs.size() == 0) begin
            if (mismatches < REPORT_MAX) begin
                $display("%t: result beat with nothing expected, index %0d value %0d",
                         $realtime, i_out.output_index, i_out.filtered_value);
            end
            mismatches++;
        end else begin
            want = expected_outputs.pop_front();
            compared++;
            compare_field("filtered_value", want.filtered, i_out.filtered_value);
            compare_field("output_index", want.index, i_out.output_index);
            compare_field("cell_tag", want.tag, i_out.cell_tag);
            compare_field("final_output", want.last, i_out.final_output);
            compare_field("peak_value", want.peak, i_out.peak_value);
            compare_field("peak_index", want.peak_idx, i_out.peak_index);
            compare_field("length_error", want.len_err, i_out.length_error);
        end
    endfunction

    // watch all three channels at each edge; results first, they never come from this beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < REG_COUNT; t++) coef_q[t] = '0;
            clear_pulse();
            expected_outputs.delete();
        end else begin
            if (i_out.valid && i_out.ready) check_result();
            if (i_cfg.valid && i_cfg.ready && i_cfg.index >= REG_COEF_0 &&
                i_cfg.index < REG_COEF_0 + REG_COUNT) begin
                coef_q[i_cfg.index - REG_COEF_0] = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                filter_sample(i_in.sample, i_in.cell_id, i_in.pulse_last);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_outputs.size();
        o_checked    <= compared;
    end

endmodule

>>> dv/matched_filter_peak_finder_top_tb.sv
// matched_filter_peak_finder_top_tb: pulse stimulus, coefficient sets and verdict for the peak finder
`timescale 1ns / 1ps

module matched_filter_peak_finder_top_tb;
    import mfpf_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int LONG_PULSE      = 70;
    localparam int TIMEOUT_NS      = 1_000_000;

    localparam logic signed [COEF_W-1:0]   COEF_MAX   = 18'sh1FFFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = 18'sh20000;
    localparam logic signed [COEF_W-1:0]   COEF_ONE   = 18'sh10000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic idle_on;
    int   mismatches;
    int   pending;
    int   checked;
    int   n_samples = 0;
    int   n_pulses = 0;
    int   n_overlong = 0;
    int   n_coef_sets = 0;

    logic signed [COEF_W-1:0] coef_plan [REG_COUNT];

    mfpf_in_if  in_ch ();
    mfpf_out_if out_ch ();
    mfpf_cfg_if cfg_ch ();

    matched_filter_peak_finder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mfpf_output_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side backpressure in random bursts
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            out_ch.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    function automatic logic [CELL_W-1:0] rand_cell();
        return {$urandom, $urandom};
    endfunction

    // one sample beat, valid left high for a following beat
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s,
                               input logic [CELL_W-1:0] cell_in, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.sample     <= s;
        in_ch.cell_id    <= cell_in;
        in_ch.pulse_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_samples++;
        if (last) n_pulses++;
    endtask

    // pause the sender until every expected result has come, then let the pipe settle
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    // all taps from coef_plan, plus a write past the last register that must be dropped
    task automatic load_coefs();
        for (int t = 0; t < REG_COUNT; t++) write_reg(REG_COEF_0 + CFG_IW'(t), coef_plan[t]);
        write_reg(CFG_IW'($urandom_range(REG_COEF_0 + REG_COUNT, (1 << CFG_IW) - 1)),
                  COEF_W'($urandom));
        cfg_ch.valid <= 1'b0;
        n_coef_sets++;
    endtask

    task automatic plan_coefs(input int phase);
        for (int t = 0; t < REG_COUNT; t++) begin
            case (phase % 5)
                0: coef_plan[t] = COEF_W'($urandom);
                1: coef_plan[t] = COEF_MAX;
                2: begin
                    case ($urandom_range(0, 3))
                        0: coef_plan[t] = COEF_MIN;
                        1: coef_plan[t] = COEF_MAX;
                        2: coef_plan[t] = '0;
                        default: coef_plan[t] = COEF_W'($urandom);
                    endcase
                end
                3: coef_plan[t] = (t == DEF_TAPS / 2) ? COEF_ONE :
                                  COEF_W'($urandom_range(0, 8191)) - 18'sd4096;
                default: coef_plan[t] = COEF_MIN;
            endcase
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return $urandom_range(1, 6);
        if (r < 17) return $urandom_range(7, 20);
        return $urandom_range(DEF_MAX_PULSE_LEN - 2, DEF_MAX_PULSE_LEN + 4);
    endfunction

    // a pulse of random content; later samples carry stray cell ids that must not be latched
    task automatic send_pulse(input int len);
        logic [CELL_W-1:0]         pulse_cell;
        logic signed [SAMPLE_W-1:0] flat;
        logic signed [SAMPLE_W-1:0] s;
        int                         style;
        pulse_cell = rand_cell();
        flat       = SAMPLE_W'($urandom);
        style      = $urandom_range(0, 5);
        if (len > DEF_MAX_PULSE_LEN) n_overlong++;
        for (int i = 0; i < len; i++) begin
            case (style)
                0: begin
                    case ($urandom_range(0, 3))
                        0: s = SAMPLE_MIN;
                        1: s = SAMPLE_MAX;
                        2: s = '0;
                        default: s = -16'sd1;
                    endcase
                end
                1: s = flat;
                default: s = SAMPLE_W'($urandom);
            endcase
            send_sample(s, (i == 0 || $urandom_range(0, 1)) ? pulse_cell : rand_cell(),
                        i == len - 1);
        end
    endtask

    // stimulus
    initial begin
        logic [CELL_W-1:0] pulse_cell;
        int                pulse_len;
        int                phase_items;
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.sample     <= '0;
        in_ch.cell_id    <= '0;
        in_ch.pulse_last <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_COEF_0;
        cfg_ch.data      <= '0;
        idle_on = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero taps straight out of reset: every output and the peak are zero
        send_sample(SAMPLE_MAX, '1, 1'b0);
        send_sample(SAMPLE_MIN, '1, 1'b1);
        drain_results();

        // full-scale mixed taps, short pulses that flush everything on their last sample
        coef_plan = '{COEF_MAX, COEF_MIN, COEF_ONE, -COEF_ONE, 18'sd1};
        load_coefs();
        send_sample(SAMPLE_MIN, '0, 1'b1);
        pulse_cell = rand_cell();
        send_sample(SAMPLE_MAX, pulse_cell, 1'b0);
        send_sample(-16'sd1, pulse_cell, 1'b1);
        pulse_cell = rand_cell();
        send_sample(SAMPLE_MIN, pulse_cell, 1'b0);
        send_sample(SAMPLE_MAX, pulse_cell, 1'b0);
        send_sample('0, pulse_cell, 1'b1);
        pulse_cell = rand_cell();
        for (int i = 0; i < 6; i++) begin
            send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, pulse_cell, i == 5);
        end
        drain_results();

        // most negative taps against most negative samples: largest positive sums
        coef_plan = '{default: COEF_MIN};
        load_coefs();
        pulse_cell = rand_cell();
        for (int i = 0; i < 4; i++) send_sample(SAMPLE_MIN, pulse_cell, i == 3);
        drain_results();

        // unit center tap on a flat pulse: equal outputs, the first one is the peak
        coef_plan = '{default: '0};
        coef_plan[DEF_TAPS / 2] = COEF_ONE;
        load_coefs();
        pulse_cell = rand_cell();
        for (int i = 0; i < 5; i++) send_sample(16'sd1234, pulse_cell, i == 4);
        drain_results();

        // random pulses over several tap sets, no idling in the last one
        for (int phase = 0; phase < PHASES; phase++) begin
            idle_on = (phase != PHASES - 1);
            plan_coefs(phase);
            load_coefs();
            phase_items = 0;
            if (phase == 3) begin
                send_pulse(LONG_PULSE);
                phase_items += LONG_PULSE;
            end
            while (phase_items < ITEMS_PER_PHASE) begin
                pulse_len = pick_length();
                send_pulse(pulse_len);
                phase_items += pulse_len;
                if (phase == 2 && $urandom_range(0, 3) == 0) drain_results();
            end
            drain_results();
        end

        $display("covered %0d samples in %0d pulses (%0d overlong) under %0d tap sets",
                 n_samples, n_pulses, n_overlong, n_coef_sets);
        $display("%0d outputs compared, %0d mismatches, %0d outputs missing",
                 checked, mismatches, pending);
        if (mismatches == 0 && pending == 0) begin
            $display("matched_filter_peak_finder_top_tb OK");
        end else begin
            $display("matched_filter_peak_finder_top_tb NOT OK");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d outputs still expected", pending);
        $display("matched_filter_peak_finder_top_tb NOT OK");
        $finish;
    end

endmodule
